// File: hw/rtl/lrid_pkg.sv
package lrid_pkg;

  // Field widths.
  localparam int ANGLE_W = 12;
  localparam int RANGE_W = 14;
  localparam int POSE_W  = 13;
  localparam int COUNT_W = 9;
  localparam int SINE_W  = 15;   // table entry, 0..16384
  localparam int SVAL_W  = 16;   // signed sine or cosine, Q1.14
  localparam int POINT_W = 32;   // field coordinate in Q.14 millimetres
  localparam int FRAC_W  = 14;

  // Defaults of the top-level parameters.
  localparam int NEAR_LIMIT_MM_DEF   = 500;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Register file.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_POSE_X        = 3'd0,
    REG_POSE_Y        = 3'd1,
    REG_POSE_HEADING  = 3'd2,
    REG_REGION_X_MIN  = 3'd3,
    REG_REGION_X_MAX  = 3'd4,
    REG_REGION_Y_MIN  = 3'd5,
    REG_REGION_Y_MAX  = 3'd6,
    REG_HIT_THRESHOLD = 3'd7
  } reg_idx_t;

  localparam logic signed [POSE_W-1:0]  RST_REGION_X_MIN  = -13'sd1350;
  localparam logic signed [POSE_W-1:0]  RST_REGION_X_MAX  = 13'sd1350;
  localparam logic signed [POSE_W-1:0]  RST_REGION_Y_MIN  = -13'sd700;
  localparam logic signed [POSE_W-1:0]  RST_REGION_Y_MAX  = 13'sd850;
  localparam logic [COUNT_W-1:0]        RST_HIT_THRESHOLD = 9'd5;
  localparam logic [COUNT_W-1:0]        COUNT_MAX         = '1;

  // A quarter turn in angle units; the cosine is the sine a quarter turn later.
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 12'd1024;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          SERIES_TERMS = 12;

  // Rounded-up reciprocals in Q64 of the series divisors (2n)(2n+1). The
  // dividends stay far below 2^64 / 600, so the product gives the exact floor.
  localparam logic [127:0] SERIES_RECIP [1:SERIES_TERMS] = '{
    ((128'd1 << 64) / 128'd6)   + 128'd1,
    ((128'd1 << 64) / 128'd20)  + 128'd1,
    ((128'd1 << 64) / 128'd42)  + 128'd1,
    ((128'd1 << 64) / 128'd72)  + 128'd1,
    ((128'd1 << 64) / 128'd110) + 128'd1,
    ((128'd1 << 64) / 128'd156) + 128'd1,
    ((128'd1 << 64) / 128'd210) + 128'd1,
    ((128'd1 << 64) / 128'd272) + 128'd1,
    ((128'd1 << 64) / 128'd342) + 128'd1,
    ((128'd1 << 64) / 128'd420) + 128'd1,
    ((128'd1 << 64) / 128'd506) + 128'd1,
    ((128'd1 << 64) / 128'd600) + 128'd1
  };

  // Quarter-wave sine entry k of a table with 2^bits steps, Q1.14.
  // Taylor series in Q30 fixed point, rounded to Q14. Used at elaboration only.
  function automatic logic [SINE_W-1:0] sine_entry(input int k, input int bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [127:0]       prod;
    logic signed [63:0] sum;
    logic [63:0]        q;
    x    = (HALF_PI_Q30 * 64'(k)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      prod = 128'((term * x2) >> 30) * SERIES_RECIP[n];
      term = 64'(prod >> 64);
      if ((n % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    q = (unsigned'(sum) + 64'd32768) >> 16;
    if (q > 64'd16384) begin
      q = 64'd16384;
    end
    return SINE_W'(q);
  endfunction

endpackage

// File: hw/rtl/lrid_if.sv
interface lrid_sample_if;
  logic                           valid;
  logic                           ready;
  logic [lrid_pkg::ANGLE_W-1:0]   beam_angle;
  logic [lrid_pkg::RANGE_W-1:0]   range_mm;
  logic                           scan_end;

  modport source (output valid, output beam_angle, output range_mm, output scan_end,
                  input ready);
  modport sink   (input valid, input beam_angle, input range_mm, input scan_end,
                  output ready);
endinterface

interface lrid_result_if;
  logic                           valid;
  logic                           ready;
  logic [lrid_pkg::COUNT_W-1:0]   hit_count;
  logic                           stop_flag;

  modport source (output valid, output hit_count, output stop_flag, input ready);
  modport sink   (input valid, input hit_count, input stop_flag, output ready);
endinterface

// File: hw/rtl/lrid_ram.sv
module lrid_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/lrid_sine.sv
module lrid_sine #(
  parameter int SINE_TABLE_BITS = lrid_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rd_en,
  input  logic [lrid_pkg::ANGLE_W-1:0]       angle,
  output logic                               ready,
  output logic signed [lrid_pkg::SVAL_W-1:0] sin_val,
  output logic signed [lrid_pkg::SVAL_W-1:0] cos_val
);

  localparam int TBL_N = 1 << SINE_TABLE_BITS;
  localparam int DEPTH = TBL_N + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PH_W  = lrid_pkg::ANGLE_W - 2;

  // Phase to table index, then mirrored in the odd quadrants.
  function automatic logic [AW-1:0] tbl_addr(input logic [lrid_pkg::ANGLE_W-1:0] a);
    logic [PH_W+SINE_TABLE_BITS-1:0] scaled;
    logic [AW-1:0]                   idx;
    scaled = {a[PH_W-1:0], {SINE_TABLE_BITS{1'b0}}} >> PH_W;
    idx    = AW'(scaled[SINE_TABLE_BITS-1:0]);
    return a[PH_W] ? (AW'(TBL_N) - idx) : idx;
  endfunction

  logic [lrid_pkg::SINE_W-1:0] rom [DEPTH];
  logic [CW-1:0]               fill_cnt;
  logic [lrid_pkg::ANGLE_W-1:0] cos_angle;
  logic [lrid_pkg::SINE_W-1:0] sin_data;
  logic [lrid_pkg::SINE_W-1:0] cos_data;
  logic                        sin_neg;
  logic                        cos_neg;
  logic signed [lrid_pkg::SVAL_W-1:0] sin_mag;
  logic signed [lrid_pkg::SVAL_W-1:0] cos_mag;

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom[k] = lrid_pkg::sine_entry(k, SINE_TABLE_BITS);
  end

  assign cos_angle = angle + lrid_pkg::QUARTER_TURN;

  // After reset the table is copied into the RAM, one entry a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      ready    <= 1'b0;
    end else if (!ready) begin
      fill_cnt <= fill_cnt + 1'b1;
      if (fill_cnt == CW'(TBL_N)) begin
        ready <= 1'b1;
      end
    end
  end

  lrid_ram #(
    .WIDTH (lrid_pkg::SINE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (!ready),
    .waddr   (fill_cnt[AW-1:0]),
    .wdata   (rom[fill_cnt[AW-1:0]]),
    .re      (rd_en),
    .raddr_a (tbl_addr(angle)),
    .raddr_b (tbl_addr(cos_angle)),
    .rdata_a (sin_data),
    .rdata_b (cos_data)
  );

  // The lower half turn is positive, the upper half negative.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      sin_neg <= angle[lrid_pkg::ANGLE_W-1];
      cos_neg <= cos_angle[lrid_pkg::ANGLE_W-1];
    end
  end

  assign sin_mag = signed'(lrid_pkg::SVAL_W'(sin_data));
  assign cos_mag = signed'(lrid_pkg::SVAL_W'(cos_data));
  assign sin_val = sin_neg ? -sin_mag : sin_mag;
  assign cos_val = cos_neg ? -cos_mag : cos_mag;

endmodule

// File: hw/rtl/lidar_region_intrusion_detect.sv
// Lidar region intrusion detector.
// The sample channel takes one lidar return per request: bearing, range and a
// scan_end mark. Returns nearer than NEAR_LIMIT_MM are placed in the field
// using the loaded robot pose and tested against the watched rectangle. On the
// request that carries scan_end, the result channel delivers the in-region
// count of the scan and the stop flag, and the count starts over.
// Throughput is one sample request per cycle unless the pipeline holds. A
// result becomes valid after its scan_end request has passed the registered
// sine table read and the registered two multiplies, and the compares and
// count update have loaded the output register.
// After reset the sine RAM is filled from the constant table, 2^SINE_TABLE_BITS
// + 1 entries (1025 at the default); sample ready stays low until then, while
// register writes are taken as usual. Registers reset to their documented values.
// A waiting result does not block samples without scan_end; only a scan_end
// request reaching the end of the pipeline while the output register is still
// full holds the pipeline and drops sample ready. The user must write registers
// over APB only while no scan is in flight; the block does not enforce this.
module lidar_region_intrusion_detect #(
  parameter int NEAR_LIMIT_MM   = lrid_pkg::NEAR_LIMIT_MM_DEF,
  parameter int SINE_TABLE_BITS = lrid_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  lrid_sample_if.sink                 sample,
  lrid_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrid_pkg::APB_AW-1:0] paddr,
  input  logic [lrid_pkg::APB_DW-1:0] pwdata,
  output logic [lrid_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int PW = lrid_pkg::POINT_W;
  localparam int FW = lrid_pkg::FRAC_W;

  // Configuration registers.
  logic signed [lrid_pkg::POSE_W-1:0]  pose_x;
  logic signed [lrid_pkg::POSE_W-1:0]  pose_y;
  logic [lrid_pkg::ANGLE_W-1:0]        pose_heading;
  logic signed [lrid_pkg::POSE_W-1:0]  region_x_min;
  logic signed [lrid_pkg::POSE_W-1:0]  region_x_max;
  logic signed [lrid_pkg::POSE_W-1:0]  region_y_min;
  logic signed [lrid_pkg::POSE_W-1:0]  region_y_max;
  logic [lrid_pkg::COUNT_W-1:0]        hit_threshold;
  lrid_pkg::reg_idx_t                  reg_idx;
  logic                                cfg_wr;

  // Pipeline.
  logic                                adv;
  logic                                sine_ready;
  logic [lrid_pkg::ANGLE_W-1:0]        total_angle;
  logic signed [lrid_pkg::SVAL_W-1:0]  sin_val;
  logic signed [lrid_pkg::SVAL_W-1:0]  cos_val;
  logic                                s1_valid;
  logic                                s1_near;
  logic                                s1_last;
  logic [lrid_pkg::RANGE_W-1:0]        s1_range;
  logic                                s2_valid;
  logic                                s2_near;
  logic                                s2_last;
  logic signed [PW-1:0]                s2_px;
  logic signed [PW-1:0]                s2_py;
  logic signed [PW-1:0]                px_next;
  logic signed [PW-1:0]                py_next;
  logic                                in_region;
  logic                                hit;
  logic [lrid_pkg::COUNT_W-1:0]        hits;
  logic [lrid_pkg::COUNT_W-1:0]        hits_next;
  logic                                scan_done;

  // Output register.
  logic                                out_valid;
  logic [lrid_pkg::COUNT_W-1:0]        out_count;
  logic                                out_stop;

  //--------------------------------------------------------------------------
  // APB register file. Writes land in the access phase; reads are immediate.
  //--------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = lrid_pkg::reg_idx_t'(paddr[lrid_pkg::APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x        <= '0;
      pose_y        <= '0;
      pose_heading  <= '0;
      region_x_min  <= lrid_pkg::RST_REGION_X_MIN;
      region_x_max  <= lrid_pkg::RST_REGION_X_MAX;
      region_y_min  <= lrid_pkg::RST_REGION_Y_MIN;
      region_y_max  <= lrid_pkg::RST_REGION_Y_MAX;
      hit_threshold <= lrid_pkg::RST_HIT_THRESHOLD;
    end else if (cfg_wr) begin
      case (reg_idx)
        lrid_pkg::REG_POSE_X:        pose_x        <= pwdata[lrid_pkg::POSE_W-1:0];
        lrid_pkg::REG_POSE_Y:        pose_y        <= pwdata[lrid_pkg::POSE_W-1:0];
        lrid_pkg::REG_POSE_HEADING:  pose_heading  <= pwdata[lrid_pkg::ANGLE_W-1:0];
        lrid_pkg::REG_REGION_X_MIN:  region_x_min  <= pwdata[lrid_pkg::POSE_W-1:0];
        lrid_pkg::REG_REGION_X_MAX:  region_x_max  <= pwdata[lrid_pkg::POSE_W-1:0];
        lrid_pkg::REG_REGION_Y_MIN:  region_y_min  <= pwdata[lrid_pkg::POSE_W-1:0];
        lrid_pkg::REG_REGION_Y_MAX:  region_y_max  <= pwdata[lrid_pkg::POSE_W-1:0];
        lrid_pkg::REG_HIT_THRESHOLD: hit_threshold <= pwdata[lrid_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lrid_pkg::REG_POSE_X:        prdata = lrid_pkg::APB_DW'(pose_x);
      lrid_pkg::REG_POSE_Y:        prdata = lrid_pkg::APB_DW'(pose_y);
      lrid_pkg::REG_POSE_HEADING:  prdata = lrid_pkg::APB_DW'(pose_heading);
      lrid_pkg::REG_REGION_X_MIN:  prdata = lrid_pkg::APB_DW'(region_x_min);
      lrid_pkg::REG_REGION_X_MAX:  prdata = lrid_pkg::APB_DW'(region_x_max);
      lrid_pkg::REG_REGION_Y_MIN:  prdata = lrid_pkg::APB_DW'(region_y_min);
      lrid_pkg::REG_REGION_Y_MAX:  prdata = lrid_pkg::APB_DW'(region_y_max);
      lrid_pkg::REG_HIT_THRESHOLD: prdata = lrid_pkg::APB_DW'(hit_threshold);
      default:                     prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Flow control. The whole pipeline moves together; it only holds when a
  // finished scan reaches the count stage and the output register cannot
  // take it in this cycle.
  //--------------------------------------------------------------------------
  assign scan_done    = s2_valid && s2_last;
  assign adv          = !(scan_done && out_valid && !result.ready);
  assign sample.ready = adv && sine_ready;

  //--------------------------------------------------------------------------
  // Stage 1: sine and cosine of the field bearing come out of the table RAM.
  //--------------------------------------------------------------------------
  assign total_angle = sample.beam_angle + pose_heading;

  lrid_sine #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (adv),
    .angle   (total_angle),
    .ready   (sine_ready),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= sample.valid && sample.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_range <= sample.range_mm;
      s1_last  <= sample.scan_end;
      s1_near  <= (lrid_pkg::RANGE_W + 1)'(sample.range_mm) <
                  (lrid_pkg::RANGE_W + 1)'(NEAR_LIMIT_MM);
    end
  end

  //--------------------------------------------------------------------------
  // Stage 2: rotate and offset. The point is kept exact in Q.14 millimetres.
  //--------------------------------------------------------------------------
  assign px_next = (PW'(pose_x) <<< FW) + signed'(PW'(s1_range)) * PW'(cos_val);
  assign py_next = (PW'(pose_y) <<< FW) + signed'(PW'(s1_range)) * PW'(sin_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_px   <= px_next;
      s2_py   <= py_next;
      s2_near <= s1_near;
      s2_last <= s1_last;
    end
  end

  //--------------------------------------------------------------------------
  // Count stage: strict rectangle test, saturating count, and the result of a
  // finished scan into the output register.
  //--------------------------------------------------------------------------
  assign in_region = (s2_px > (PW'(region_x_min) <<< FW)) &&
                     (s2_px < (PW'(region_x_max) <<< FW)) &&
                     (s2_py > (PW'(region_y_min) <<< FW)) &&
                     (s2_py < (PW'(region_y_max) <<< FW));
  assign hit       = s2_valid && s2_near && in_region;

  assign hits_next = (hit && (hits != lrid_pkg::COUNT_MAX)) ? (hits + 1'b1) : hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      hits <= '0;
    end else if (adv && s2_valid) begin
      hits <= s2_last ? '0 : hits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && scan_done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && scan_done) begin
      out_count <= hits_next;
      out_stop  <= hits_next > hit_threshold;
    end
  end

  assign result.valid     = out_valid;
  assign result.hit_count = out_count;
  assign result.stop_flag = out_stop;

`ifndef SYNTHESIS
  // The count restarts right after a scan is closed.
  a_clear_after_scan: assert property (@(posedge clk) disable iff (rst)
    (adv && scan_done) |=> (hits == '0))
    else $error("hit count not cleared after scan end");

  // Between scans the count never goes down.
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(adv && scan_done)) |-> (hits >= $past(hits)))
    else $error("hit count decreased within a scan");

  // A delivered stop flag agrees with the delivered count.
  a_stop_matches: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.stop_flag == (result.hit_count > hit_threshold)))
    else $error("stop flag inconsistent with hit count");

  // No sample is taken before the sine RAM is loaded.
  a_no_sample_during_fill: assert property (@(posedge clk) disable iff (rst)
    !sine_ready |-> !s1_valid || $past(sine_ready))
    else $error("sample accepted while sine table was loading");
`endif

endmodule
